### src/ppdb_pkg.sv
// Shared types and constants for the positional PID controller with dead band.
// Used by ppdb_regs and position_pid_dead_band_core.
package ppdb_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // Register index, taken from paddr[5:3]
  localparam logic [2:0] REG_SETPOINT       = 3'd0;
  localparam logic [2:0] REG_PROP_GAIN      = 3'd1;
  localparam logic [2:0] REG_INTEG_GAIN     = 3'd2;
  localparam logic [2:0] REG_DERIV_GAIN     = 3'd3;
  localparam logic [2:0] REG_DEAD_BAND      = 3'd4;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd6;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Gains are Q16.16; the fraction only rides through to the Q31.16 drive.
  typedef struct packed {
    logic [30:0] setpoint;
    logic [31:0] proportional_gain;
    logic [31:0] integral_gain;
    logic [31:0] derivative_gain;
    logic [29:0] dead_band;
    logic [30:0] integral_limit;
    logic [46:0] output_limit;
  } ppdb_cfg_t;

endpackage

### src/ppdb_regs.sv
// APB-style configuration register file for the PID controller.
// Depends on ppdb_pkg for the register map and the ppdb_cfg_t struct.
module ppdb_regs
  import ppdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output ppdb_cfg_t         cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SETPOINT:       cfg.setpoint          <= pwdata[30:0];
        REG_PROP_GAIN:      cfg.proportional_gain <= pwdata[31:0];
        REG_INTEG_GAIN:     cfg.integral_gain     <= pwdata[31:0];
        REG_DERIV_GAIN:     cfg.derivative_gain   <= pwdata[31:0];
        REG_DEAD_BAND:      cfg.dead_band         <= pwdata[29:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit    <= pwdata[30:0];
        REG_OUTPUT_LIMIT:   cfg.output_limit      <= pwdata[46:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SETPOINT:       prdata = {33'd0, cfg.setpoint};
      REG_PROP_GAIN:      prdata = {32'd0, cfg.proportional_gain};
      REG_INTEG_GAIN:     prdata = {32'd0, cfg.integral_gain};
      REG_DERIV_GAIN:     prdata = {32'd0, cfg.derivative_gain};
      REG_DEAD_BAND:      prdata = {34'd0, cfg.dead_band};
      REG_INTEGRAL_LIMIT: prdata = {33'd0, cfg.integral_limit};
      REG_OUTPUT_LIMIT:   prdata = {17'd0, cfg.output_limit};
      default:            prdata = '0;
    endcase
  end

endmodule

### src/position_pid_dead_band_core.sv
// Top level of the positional PID controller with dead band and anti-windup.
// Depends on ppdb_pkg and ppdb_regs.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     operation, position
//   result    out        out_valid / out_stall   drive, in_dead_band
//   config    in         psel/penable/pwrite     paddr, pwdata -> prdata
//
// Five register stages: input, error/integral, products, sum, clamp/result.
// One transaction per cycle sustained while out_stall is low; after accept a result passes stages B, C, D and E.
// Integral sum and previous error update as a transaction leaves the input stage.
// Each stage holds while the one after it is full and stalled; bubbles close up.
// rst is synchronous and clears the valid bits, the state and the config registers, not the data registers.
module position_pid_dead_band_core
  import ppdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [30:0]       position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [47:0]       drive,
  output logic              in_dead_band,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  ppdb_cfg_t cfg;

  ppdb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage valids and load enables
  logic va, vb, vc, vd;
  logic ld_a, ld_b, ld_c, ld_d, ld_e;

  assign ld_e     = !out_valid || !out_stall;
  assign ld_d     = !vd || ld_e;
  assign ld_c     = !vc || ld_d;
  assign ld_b     = !vb || ld_c;
  assign ld_a     = !va || ld_b;
  assign in_stall = !ld_a;

  // Stage A: input register
  logic        a_op;
  logic [30:0] a_pos;

  // Controller state
  logic signed [31:0] integral_sum, integral_sum_next;
  logic signed [31:0] previous_error, previous_error_next;

  // Stage A -> B combinational
  logic signed [31:0] err;
  logic signed [32:0] err_x, band_x;
  logic               out_of_band;
  logic signed [33:0] acc, ilim_x;
  logic signed [31:0] err_sel;
  logic signed [32:0] diff;
  logic               inband;

  always_comb begin
    err         = $signed({cfg.setpoint[30], cfg.setpoint}) - $signed({a_pos[30], a_pos});
    err_x       = {err[31], err};
    band_x      = $signed({3'b000, cfg.dead_band});
    out_of_band = (err_x > band_x) || (err_x < -band_x);
    acc         = $signed({{2{integral_sum[31]}}, integral_sum}) + $signed({{2{err[31]}}, err});
    ilim_x      = $signed({3'b000, cfg.integral_limit});

    if (a_op == OP_CLEAR) begin
      integral_sum_next   = '0;
      previous_error_next = '0;
      err_sel             = '0;
      diff                = '0;
      inband              = 1'b0;
    end else begin
      if (out_of_band) begin
        err_sel = err;
        inband  = 1'b0;
        if (acc > ilim_x) begin
          integral_sum_next = ilim_x[31:0];
        end else if (acc < -ilim_x) begin
          integral_sum_next = 32'(-ilim_x);
        end else begin
          integral_sum_next = acc[31:0];
        end
      end else begin
        err_sel           = '0;
        inband            = 1'b1;
        integral_sum_next = '0;
      end
      previous_error_next = err_sel;
      diff = $signed({err_sel[31], err_sel}) - $signed({previous_error[31], previous_error});
    end
  end

  // Stage B: error, clamped integral, error difference
  logic signed [31:0] b_err, b_sum;
  logic signed [32:0] b_diff;
  logic               b_inband;

  // Stage C: products
  logic signed [63:0] c_prod_p, c_prod_i;
  logic signed [64:0] c_prod_d;
  logic               c_inband;

  // Stage D: sum of products, formed wide enough not to wrap
  logic signed [65:0] d_sum;
  logic               d_inband;
  logic signed [65:0] olim_x;

  assign olim_x = $signed({19'd0, cfg.output_limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      va             <= 1'b0;
      vb             <= 1'b0;
      vc             <= 1'b0;
      vd             <= 1'b0;
      out_valid      <= 1'b0;
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      if (ld_a) va <= in_valid;
      if (ld_b) vb <= va;
      if (ld_c) vc <= vb;
      if (ld_d) vd <= vc;
      if (ld_e) out_valid <= vd;
      if (ld_b && va) begin
        integral_sum   <= integral_sum_next;
        previous_error <= previous_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      a_op  <= operation;
      a_pos <= position;
    end
    if (ld_b) begin
      b_err    <= err_sel;
      b_sum    <= (a_op == OP_CLEAR) ? 32'sd0 : integral_sum_next;
      b_diff   <= diff;
      b_inband <= inband;
    end
    if (ld_c) begin
      c_prod_p <= 64'(b_err) * 64'($signed(cfg.proportional_gain));
      c_prod_i <= 64'(b_sum) * 64'($signed(cfg.integral_gain));
      c_prod_d <= 65'(b_diff) * 65'($signed(cfg.derivative_gain));
      c_inband <= b_inband;
    end
    if (ld_d) begin
      d_sum    <= 66'(c_prod_p) + 66'(c_prod_i) + 66'(c_prod_d);
      d_inband <= c_inband;
    end
    if (ld_e) begin
      // Output limit is far inside the 66-bit range, so one clamp covers saturation
      if (d_sum > olim_x) begin
        drive <= olim_x[47:0];
      end else if (d_sum < -olim_x) begin
        drive <= 48'(-olim_x);
      end else begin
        drive <= d_sum[47:0];
      end
      in_dead_band <= d_inband;
    end
  end

endmodule
